// ===== rtl/modexp_pkg.sv =====
`default_nettype none
package modexp_pkg;

  localparam int MOD_W     = 31;
  localparam int BASE_W    = 32;
  localparam int EXP_W     = 63;
  localparam int MUL_STEPS = 32;
  localparam int CNT_W     = 6;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [1:0] {
    MUL_ACC,
    MUL_SQ
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     acc_wr;
    logic     pw_wr;
    logic     exp_shift;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_zero;
    logic exp_lsb;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/modexp_if.sv =====
`default_nettype none
interface modexp_in_if;
  logic                              valid;
  logic                              ready;
  logic [modexp_pkg::BASE_W-1:0]     base_value;
  logic [modexp_pkg::EXP_W-1:0]      exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface modexp_out_if;
  logic                              valid;
  logic                              ready;
  logic [modexp_pkg::MOD_W-1:0]      power_result;

  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/modexp_dp.sv =====
`default_nettype none
module modexp_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [modexp_pkg::MOD_W-1:0]  cfg_data_i,
  input  wire logic [modexp_pkg::BASE_W-1:0] base_i,
  input  wire logic [modexp_pkg::EXP_W-1:0]  exp_i,
  input  wire modexp_pkg::dp_cmd_t           cmd_i,
  output modexp_pkg::dp_stat_t               stat_o,
  output logic [modexp_pkg::MOD_W-1:0]       result_o
);
  import modexp_pkg::*;

  logic [MOD_W-1:0]  mod_q;
  logic [EXP_W-1:0]  exp_q;
  logic [MOD_W-1:0]  pw_q, acc_q, r_q, a_q, res_q;
  logic [BASE_W-1:0] x_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic [MOD_W+1:0]  t0, t1, t2, m_ext;
  logic              done;

  // One bit of an interleaved modular multiply: r = 2r + bit*a, then reduce.
  // With r and a below m the sum stays below 3m, so two subtractions suffice.
  always_comb begin
    m_ext = {2'b00, mod_q};
    t0 = {1'b0, r_q, 1'b0} + (x_q[BASE_W-1] ? {2'b00, a_q} : '0);
    t1 = (t0 >= m_ext) ? t0 - m_ext : t0;
    t2 = (t1 >= m_ext) ? t1 - m_ext : t1;
  end

  assign done = busy_q && (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= MODULUS_RESET;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mod_q <= cfg_data_i;
      end
      if (cmd_i.load || cmd_i.mul_start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MUL_STEPS);
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      // Reducing the base is a multiply by one with the base as multiplier.
      exp_q <= exp_i;
      acc_q <= MOD_W'(1);
      x_q   <= base_i;
      a_q   <= MOD_W'(1);
      r_q   <= '0;
    end else begin
      if (cmd_i.acc_wr) begin
        acc_q <= r_q;
      end
      if (cmd_i.pw_wr) begin
        pw_q <= r_q;
      end
      if (cmd_i.exp_shift) begin
        exp_q <= exp_q >> 1;
      end
      if (cmd_i.mul_start) begin
        r_q <= '0;
        a_q <= pw_q;
        if (cmd_i.mul_sel == MUL_ACC) begin
          x_q <= {1'b0, acc_q};
        end else begin
          x_q <= {1'b0, pw_q};
        end
      end else if (busy_q && !done) begin
        r_q <= t2[MOD_W-1:0];
        x_q <= x_q << 1;
      end
    end
    if (cmd_i.out_load) begin
      res_q <= (mod_q < MOD_W'(2)) ? '0 : acc_q;
    end
  end

  assign stat_o.mul_done = done;
  assign stat_o.exp_zero = (exp_q == '0);
  assign stat_o.exp_lsb  = exp_q[0];
  assign result_o        = res_q;

endmodule
`default_nettype wire

// ===== rtl/modexp_ctrl.sv =====
`default_nettype none
module modexp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire modexp_pkg::dp_stat_t stat_i,
  output modexp_pkg::dp_cmd_t       cmd_o
);
  import modexp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_BIT,
    ST_ACC,
    ST_SQ
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.mul_sel = MUL_SQ;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RED;
        end
      end
      ST_RED: begin
        if (stat_i.mul_done) begin
          cmd_o.pw_wr = 1'b1;
          state_d     = ST_BIT;
        end
      end
      ST_BIT: begin
        if (stat_i.exp_zero) begin
          if (!out_valid_q || out_ready_i) begin
            cmd_o.out_load = 1'b1;
            out_valid_d    = 1'b1;
            state_d        = ST_IDLE;
          end
        end else if (stat_i.exp_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_ACC;
          state_d         = ST_ACC;
        end else begin
          cmd_o.mul_start = 1'b1;
          state_d         = ST_SQ;
        end
      end
      ST_ACC: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_wr    = 1'b1;
          cmd_o.mul_start = 1'b1;
          state_d         = ST_SQ;
        end
      end
      ST_SQ: begin
        if (stat_i.mul_done) begin
          cmd_o.pw_wr     = 1'b1;
          cmd_o.exp_shift = 1'b1;
          state_d         = ST_BIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// Modular exponentiation: power_result = base_value ** exponent mod modulus.
// The input channel carries base_value and exponent; the output channel
// carries power_result, one result per input transfer. The user must write
// the modulus register (cfg_we_i/cfg_data_i) only while the block is idle;
// the block itself does not enforce this. One shared bit-serial modular
// multiplier does all the work, one multiplier bit per cycle. An item first
// has its base reduced, then per exponent bit up to the highest set one the
// power is multiplied into the accumulator when the bit is set and then
// squared; last the result is posted. One item is in flight at a time;
// input ready is high only between items.
// The result sits in an output register, so the block finishes the next
// item's exponent loop while an earlier result waits; a stalled receiver
// holds it only at the final write-back.
// Reset empties the block and sets the modulus to 1000000007. A modulus
// below two gives zero for every input.
`default_nettype none
module modular_exponentiation (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [modexp_pkg::MOD_W-1:0] cfg_data_i,
  modexp_in_if.sink                         in_s,
  modexp_out_if.source                      out_s
);
  import modexp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  modexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_s.valid),
    .out_ready_i (out_s.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  modexp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .base_i     (in_s.base_value),
    .exp_i      (in_s.exponent),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .result_o   (out_s.power_result)
  );

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_s.valid && in_s.ready) |-> cmd.load)
    else $error("input transfer without datapath load");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_s.valid && in_s.ready) |=> !in_s.ready)
    else $error("input ready while an item is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_s.valid && !out_s.ready))
    else $error("result register overwritten while stalled");

  a_start_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |-> !in_s.ready)
    else $error("multiply started while idle");

endmodule
`default_nettype wire

// ===== verif/tb_modular_exponentiation.sv =====
module tb_modular_exponentiation;
  import modexp_pkg::*;

  localparam int IDLE_PCT = 31;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [MOD_W-1:0] cfg_data_i = '0;

  modexp_in_if in_c ();
  modexp_out_if out_c ();

  modular_exponentiation dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (in_c.sink),
    .out_s      (out_c.source)
  );

  logic [MOD_W-1:0] modulus_q = MODULUS_RESET;
  logic [MOD_W-1:0] expected_powers[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    in_c.valid = 1'b0;
    in_c.base_value = '0;
    in_c.exponent = '0;
    out_c.ready = 1'b0;
  end

  // Right-to-left square and multiply on 64-bit products.
  function automatic logic [MOD_W-1:0] mod_power(logic [BASE_W-1:0] b,
                                                 logic [EXP_W-1:0] e,
                                                 logic [MOD_W-1:0] m);
    logic [63:0] acc;
    logic [63:0] pw;
    logic [63:0] mm;
    mm = {33'd0, m};
    if (mm < 2) return '0;
    acc = 64'd1;
    pw = {32'd0, b} % mm;
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) acc = (acc * pw) % mm;
      pw = (pw * pw) % mm;
    end
    return acc[MOD_W-1:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_c.valid && out_c.ready) begin
        if (expected_powers.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time,
                   out_c.power_result);
          errors++;
        end else begin
          if (out_c.power_result !== expected_powers[0]) begin
            $display("%0t: power_result mismatch, expected %0d, actual %0d", $time,
                     expected_powers[0], out_c.power_result);
            errors++;
          end
          void'(expected_powers.pop_front());
        end
      end
      out_c.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog over cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_c.valid && in_c.ready) || (out_c.valid && out_c.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Valid stays high after a transfer until the next item or an idle cycle replaces it.
  task automatic send_power(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_c.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_c.valid <= 1'b1;
    in_c.base_value <= b;
    in_c.exponent <= e;
    do @(posedge clk_i); while (!in_c.ready);
    expected_powers.push_back(mod_power(b, e, modulus_q));
  endtask

  task automatic drain_results();
    in_c.valid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_modulus(logic [MOD_W-1:0] m);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    modulus_q = m;
  endtask

  function automatic logic [EXP_W-1:0] rand_exponent();
    logic [EXP_W-1:0] e;
    e = EXP_W'({$urandom, $urandom});
    // Short exponents keep the run fast; a few use the full width.
    case ($urandom_range(9))
      0: e = e;
      1, 2: e = e & 63'hFFFF_FFFF;
      default: e = e & ((63'd1 << $urandom_range(16)) - 63'd1);
    endcase
    return e;
  endfunction

  function automatic logic [BASE_W-1:0] rand_base();
    case ($urandom_range(5))
      0: return '1;
      1: return BASE_W'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_power('0, '0);
    send_power('1, '0);
    send_power('0, 63'd5);
    send_power('1, '1);
    send_power(32'd2, 63'd30);
    send_power(32'd1000000007, 63'd3);
    send_power(32'd1000000008, '1);
    send_power(32'hAAAA_AAAA, 63'h5555_5555_5555_5555);
    send_power(32'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
    send_power(32'd3, 63'd1000000005);
    send_power(32'd7, 63'd1);
  endtask

  task automatic test_random(int n);
    repeat (n) send_power(rand_base(), rand_exponent());
  endtask

  task automatic test_moduli();
    logic [MOD_W-1:0] mods[6];
    mods = '{31'd2, 31'h7FFF_FFFF, 31'd0, 31'd1, 31'd3, 31'h7FFF_FFFE};
    foreach (mods[i]) begin
      set_modulus(mods[i]);
      send_power('1, '1);
      send_power(32'd5, '0);
      test_random(40);
    end
    repeat (4) begin
      set_modulus(MOD_W'($urandom_range(32'h7FFF_FFFF, 2)));
      test_random(60);
    end
    set_modulus(MODULUS_RESET);
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    test_random(300);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(700);
    drain_results();
    test_no_idle();
    test_moduli();
    test_random(440);
    drain_results();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== modular_exponentiation.f =====
rtl/modexp_pkg.sv
rtl/modexp_if.sv
rtl/modexp_dp.sv
rtl/modexp_ctrl.sv
rtl/modular_exponentiation.sv
verif/tb_modular_exponentiation.sv
